### sv/shsd_pkg.sv
package shsd_pkg;

    // Field widths fixed by the interface
    localparam int OP_W        = 1;
    localparam int COUNT_W     = 32;
    localparam int SPEED_W     = 16;
    localparam int COILS_W     = 4;
    localparam int PHASE_W     = 3;
    localparam int IVL_W       = 10;

    // Defaults for the top-level parameters
    localparam int TICKS_PER_SECOND_DEF = 1000;
    localparam int STEP_COUNT_WIDTH_DEF = 32;

    // Longest step interval in ticks
    localparam logic [IVL_W-1:0] MAX_INTERVAL = 10'd1000;

    // Item codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK = 1'b0,
        OP_MOVE = 1'b1
    } op_t;

    // Half-step coil pattern for each phase
    function automatic logic [COILS_W-1:0] half_step_pattern(input logic [PHASE_W-1:0] ph);
        logic [COILS_W-1:0] pat;
        unique case (ph)
            3'd0: pat = 4'h1;
            3'd1: pat = 4'h3;
            3'd2: pat = 4'h2;
            3'd3: pat = 4'h6;
            3'd4: pat = 4'h4;
            3'd5: pat = 4'hC;
            3'd6: pat = 4'h8;
            3'd7: pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

### sv/stepper_half_step_driver_top.sv
// Half-step driver for a four-coil unipolar stepper.
// Input channel (s_*): one transfer is either a timer tick (s_op = tick) or a
// move command carrying step count, direction and speed. Result channel (m_*):
// exactly one result per input transfer, showing coil drive, phase index,
// busy flag and whether that item made a step.
// A move with nonzero count and nonzero speed computes the step interval
// TICKS_PER_SECOND / speed in a restoring divider, one quotient bit per
// cycle in state S_DIV, before its result is shown in S_OUT. Ticks,
// zero-count moves and zero-speed moves skip the divider; their result is
// valid in the cycle after the transfer. The block takes one item at a time:
// s_ready is high only when no result is pending, so a new item waits until
// the result of the last one has been taken.
// If the receiver stalls, the result is held unchanged on the m_ ports and
// s_ready stays low until the result transfer.
// Reset (aresetn low, synchronous) turns all coils off, clears the phase,
// the remaining count and the busy flag, and sets the interval to 1000 ticks.
module stepper_half_step_driver_top #(
    parameter int TICKS_PER_SECOND = shsd_pkg::TICKS_PER_SECOND_DEF,
    parameter int STEP_COUNT_WIDTH = shsd_pkg::STEP_COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [shsd_pkg::OP_W-1:0]     s_op,
    input  logic [shsd_pkg::COUNT_W-1:0]  s_step_count,
    input  logic                          s_forward,
    input  logic [shsd_pkg::SPEED_W-1:0]  s_speed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [shsd_pkg::COILS_W-1:0]  m_coils,
    output logic [shsd_pkg::PHASE_W-1:0]  m_phase_index,
    output logic                          m_busy_res,
    output logic                          m_stepped
);
    import shsd_pkg::*;

    // Quotient width: enough bits for TICKS_PER_SECOND, at least two
    localparam int QW_RAW = $clog2(TICKS_PER_SECOND + 1);
    localparam int QW     = (QW_RAW < 2) ? 2 : QW_RAW;
    localparam int CNT_W  = $clog2(QW);
    localparam int CW     = (QW > IVL_W) ? QW : IVL_W;
    localparam int SCW    = STEP_COUNT_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;

    // Motor state
    logic [PHASE_W-1:0]   phase_pos_reg, phase_pos_next;
    logic [COILS_W-1:0]   coil_reg, coil_next;
    logic [SCW-1:0]       remaining_reg, remaining_next;
    logic [IVL_W-1:0]     interval_reg, interval_next;
    logic [IVL_W-1:0]     countdown_reg, countdown_next;
    logic                 dir_reg, dir_next;
    logic                 moving_reg, moving_next;
    logic                 stepped_reg, stepped_next;

    // Pending move and divider
    logic [SCW-1:0]       cmd_count_reg, cmd_count_next;
    logic                 cmd_dir_reg, cmd_dir_next;
    logic [SPEED_W-1:0]   dvs_reg, dvs_next;
    logic [SPEED_W-1:0]   rem_reg, rem_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 in_xfer;
    logic [SCW-1:0]       in_count;
    logic [SPEED_W:0]     trial;
    logic                 trial_ge;
    logic [SPEED_W-1:0]   trial_sub;
    logic [QW-1:0]        quo_step;
    logic [SPEED_W-1:0]   rem_step;
    logic [CW-1:0]        quo_ext;
    logic [IVL_W-1:0]     ivl_clamped;
    logic [IVL_W-1:0]     cd_dec;
    logic [PHASE_W-1:0]   phase_step;
    logic [SCW-1:0]       rem_dec;

    assign s_ready       = (state_reg == S_IDLE);
    assign in_xfer       = s_valid && s_ready;
    assign in_count      = s_step_count[SCW-1:0];

    assign m_valid       = (state_reg == S_OUT);
    assign m_coils       = coil_reg;
    assign m_phase_index = phase_pos_reg;
    assign m_busy_res    = moving_reg;
    assign m_stepped     = stepped_reg;

    // One restoring division step; the difference fits the remainder width
    assign trial     = {rem_reg, quo_reg[QW-1]};
    assign trial_ge  = (trial >= {1'b0, dvs_reg});
    assign trial_sub = trial[SPEED_W-1:0] - dvs_reg;
    assign rem_step  = trial_ge ? trial_sub : trial[SPEED_W-1:0];
    assign quo_step  = {quo_reg[QW-2:0], trial_ge};

    // Clamp the finished quotient to 1..MAX_INTERVAL
    assign quo_ext = CW'(quo_step);
    always_comb begin
        if (quo_ext == '0) begin
            ivl_clamped = IVL_W'(1);
        end else if (quo_ext > CW'(MAX_INTERVAL)) begin
            ivl_clamped = MAX_INTERVAL;
        end else begin
            ivl_clamped = quo_ext[IVL_W-1:0];
        end
    end

    // Tick arithmetic
    assign cd_dec     = countdown_reg - IVL_W'(1);
    assign phase_step = dir_reg ? (phase_pos_reg + PHASE_W'(1))
                                : (phase_pos_reg - PHASE_W'(1));
    assign rem_dec    = remaining_reg - SCW'(1);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        phase_pos_next = phase_pos_reg;
        coil_next      = coil_reg;
        remaining_next = remaining_reg;
        interval_next  = interval_reg;
        countdown_next = countdown_reg;
        dir_next       = dir_reg;
        moving_next    = moving_reg;
        stepped_next   = stepped_reg;
        cmd_count_next = cmd_count_reg;
        cmd_dir_next   = cmd_dir_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    stepped_next = 1'b0;
                    state_next   = S_OUT;
                    if (op_t'(s_op) == OP_MOVE) begin
                        if (in_count == '0) begin
                            // zero count drops any move, phase kept
                            moving_next    = 1'b0;
                            remaining_next = '0;
                            countdown_next = '0;
                            coil_next      = '0;
                        end else if (s_speed == '0) begin
                            interval_next  = MAX_INTERVAL;
                            countdown_next = MAX_INTERVAL;
                            remaining_next = in_count;
                            dir_next       = s_forward;
                            moving_next    = 1'b1;
                        end else begin
                            cmd_count_next = in_count;
                            cmd_dir_next   = s_forward;
                            dvs_next       = s_speed;
                            rem_next       = '0;
                            quo_next       = QW'(TICKS_PER_SECOND);
                            cnt_next       = '0;
                            state_next     = S_DIV;
                        end
                    end else if (moving_reg) begin
                        countdown_next = cd_dec;
                        if (cd_dec == '0) begin
                            phase_pos_next = phase_step;
                            coil_next      = half_step_pattern(phase_step);
                            remaining_next = rem_dec;
                            stepped_next   = 1'b1;
                            if (rem_dec == '0) begin
                                coil_next   = '0;
                                moving_next = 1'b0;
                            end else begin
                                countdown_next = interval_reg;
                            end
                        end
                    end
                end
            end
            S_DIV: begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QW - 1)) begin
                    interval_next  = ivl_clamped;
                    countdown_next = ivl_clamped;
                    remaining_next = cmd_count_reg;
                    dir_next       = cmd_dir_reg;
                    moving_next    = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_pos_reg <= '0;
            coil_reg      <= '0;
            remaining_reg <= '0;
            interval_reg  <= MAX_INTERVAL;
            countdown_reg <= '0;
            dir_reg       <= 1'b0;
            moving_reg    <= 1'b0;
            stepped_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_pos_reg <= phase_pos_next;
            coil_reg      <= coil_next;
            remaining_reg <= remaining_next;
            interval_reg  <= interval_next;
            countdown_reg <= countdown_next;
            dir_reg       <= dir_next;
            moving_reg    <= moving_next;
            stepped_reg   <= stepped_next;
        end
    end

    // Divider and pending command, no reset needed
    always_ff @(posedge aclk) begin
        cmd_count_reg <= cmd_count_next;
        cmd_dir_reg   <= cmd_dir_next;
        dvs_reg       <= dvs_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
    end

endmodule

### sim/tb_stepper_half_step_driver_top.sv
`timescale 1ns / 1ps

module tb_stepper_half_step_driver_top;
    import shsd_pkg::*;

    localparam int TICK_RATE  = TICKS_PER_SECOND_DEF;
    localparam int STEP_BITS  = STEP_COUNT_WIDTH_DEF;
    localparam int STALL_MAX  = 2000;
    localparam int RAND_ITEMS = 100;
    localparam int HOLD_LEN   = 300;

    // Half-step coil drive per phase, bit 0 = first coil
    localparam logic [COILS_W-1:0] COIL_SEQ [8] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    typedef struct packed {
        logic [COILS_W-1:0] coils;
        logic [PHASE_W-1:0] phase;
        logic               busy;
        logic               stepped;
    } motor_out_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op;
    logic [COUNT_W-1:0]   s_step_count;
    logic                 s_forward;
    logic [SPEED_W-1:0]   s_speed;
    logic                 m_valid;
    logic                 m_ready;
    logic [COILS_W-1:0]   m_coils;
    logic [PHASE_W-1:0]   m_phase_index;
    logic                 m_busy_res;
    logic                 m_stepped;

    // Motor state as the predictor sees it
    logic [PHASE_W-1:0]   mot_phase;
    logic [COILS_W-1:0]   mot_coils;
    logic [COUNT_W-1:0]   mot_left;
    logic [IVL_W-1:0]     mot_ivl;
    logic [IVL_W-1:0]     mot_cd;
    logic                 mot_dir;
    logic                 mot_busy;

    motor_out_t           motor_q[$];
    int                   errors;
    int                   n_items;
    int                   n_moves;
    int                   n_steps;
    int                   idle_cycles;
    int                   hold_req;
    bit                   idle_on;

    stepper_half_step_driver_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_step_count  (s_step_count),
        .s_forward     (s_forward),
        .s_speed       (s_speed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coils       (m_coils),
        .m_phase_index (m_phase_index),
        .m_busy_res    (m_busy_res),
        .m_stepped     (m_stepped)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Ticks per step for a given speed, clamped to 1..1000
    function automatic logic [IVL_W-1:0] ticks_per_step(logic [SPEED_W-1:0] spd);
        int q;
        if (spd == 0) begin
            return MAX_INTERVAL;
        end
        q = TICK_RATE / int'(spd);
        if (q < 1) q = 1;
        if (q > int'(MAX_INTERVAL)) q = int'(MAX_INTERVAL);
        return IVL_W'(q);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Apply one item to the motor state and return the result it gives
    function automatic motor_out_t advance_motor(op_t op, logic [COUNT_W-1:0] cnt,
                                                 logic fwd, logic [SPEED_W-1:0] spd);
        motor_out_t r;
        logic [63:0] used;
        r.stepped = 1'b0;
        used = 64'(cnt) & ((64'd1 << STEP_BITS) - 64'd1);
        if (op == OP_MOVE) begin
            if (used == 0) begin
                // zero count drops any move, keeps the phase
                mot_busy  = 1'b0;
                mot_left  = '0;
                mot_cd    = '0;
                mot_coils = '0;
            end else begin
                mot_ivl  = ticks_per_step(spd);
                mot_cd   = mot_ivl;
                mot_left = COUNT_W'(used);
                mot_dir  = fwd;
                mot_busy = 1'b1;
            end
        end else if (mot_busy) begin
            mot_cd = mot_cd - 1'b1;
            if (mot_cd == 0) begin
                mot_phase = mot_dir ? mot_phase + 1'b1 : mot_phase - 1'b1;
                mot_coils = COIL_SEQ[mot_phase];
                mot_left  = mot_left - 1'b1;
                r.stepped = 1'b1;
                if (mot_left == 0) begin
                    mot_coils = '0;
                    mot_busy  = 1'b0;
                end else begin
                    mot_cd = mot_ivl;
                end
            end
        end
        r.coils = mot_coils;
        r.phase = mot_phase;
        r.busy  = mot_busy;
        return r;
    endfunction

    // Offer one item, wait for the transfer, record the expected result
    task automatic push_item(op_t op, logic [COUNT_W-1:0] cnt, logic fwd,
                             logic [SPEED_W-1:0] spd);
        motor_out_t r;
        if (idle_on && $urandom_range(0, 99) < 30) begin
            s_valid = 1'b0;
            repeat (gap_len()) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_op         = op;
        s_step_count = cnt;
        s_forward    = fwd;
        s_speed      = spd;
        do @(posedge aclk); while (!s_ready);
        r = advance_motor(op, cnt, fwd, spd);
        motor_q.push_back(r);
        n_items++;
        if (op == OP_MOVE) n_moves++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Tick with junk in the fields the block ignores on a tick
    task automatic push_ticks(int n);
        repeat (n) push_item(OP_TICK, $urandom(), 1'($urandom_range(0, 1)),
                             SPEED_W'($urandom_range(0, 65535)));
    endtask

    task automatic wait_drained();
        while (motor_q.size() != 0) @(negedge aclk);
    endtask

    // Result channel: random stalls plus a long hold on request
    initial begin
        int stall_left;
        int hold_cnt;
        stall_left = 0;
        hold_cnt   = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 25)
                stall_left = gap_len();
            m_ready = aresetn && hold_cnt == 0 && stall_left == 0;
            if (hold_cnt > 0) hold_cnt--;
            if (stall_left > 0) stall_left--;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        motor_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (motor_q.size() == 0) begin
                $display("%0t: unexpected result coils=%h phase=%0d busy=%b stepped=%b",
                         $time, m_coils, m_phase_index, m_busy_res, m_stepped);
                errors++;
            end else begin
                e = motor_q.pop_front();
                if (m_coils !== e.coils) begin
                    $display("%0t: coils expected %h actual %h", $time, e.coils, m_coils);
                    errors++;
                end
                if (m_phase_index !== e.phase) begin
                    $display("%0t: phase_index expected %0d actual %0d",
                             $time, e.phase, m_phase_index);
                    errors++;
                end
                if (m_busy_res !== e.busy) begin
                    $display("%0t: busy_res expected %b actual %b", $time, e.busy, m_busy_res);
                    errors++;
                end
                if (m_stepped !== e.stepped) begin
                    $display("%0t: stepped expected %b actual %b", $time, e.stepped, m_stepped);
                    errors++;
                end
                if (m_stepped === 1'b1) n_steps++;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_MAX) begin
                    $display("%0t: no transfer for %0d cycles", $time, STALL_MAX);
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    // Ticks while idle and a zero-count move from reset
    task automatic test_idle_ops();
        push_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        push_item(OP_TICK, 32'h0, 1'b0, 16'h0);
        push_item(OP_MOVE, 32'h0, 1'b1, 16'hFFFF);
    endtask

    // Plain moves run to completion, including a backward wrap
    task automatic test_step_runs();
        push_item(OP_MOVE, 32'd3, 1'b1, 16'd1000);
        push_ticks(4);
        push_item(OP_MOVE, 32'd5, 1'b0, 16'd500);
        push_ticks(10);
        push_item(OP_MOVE, 32'd1, 1'b1, 16'd1001);
        push_ticks(2);
    endtask

    // New move mid-run keeps the phase; zero count stops the motor
    task automatic test_replace_stop();
        push_item(OP_MOVE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        push_ticks(2);
        push_item(OP_MOVE, 32'd2, 1'b0, 16'd333);
        push_ticks(2);
        push_item(OP_MOVE, 32'h0, 1'b0, 16'd7);
        push_ticks(1);
    endtask

    // Longest interval: speed 0 and speed 1 both give 1000 ticks per step
    task automatic test_slow_interval();
        push_item(OP_MOVE, 32'd1, 1'b1, 16'd0);
        push_ticks(1001);
        push_item(OP_MOVE, 32'd3, 1'b1, 16'd1);
        push_ticks(5);
        push_item(OP_MOVE, 32'h0, 1'b1, 16'd1);
    endtask

    // Receiver holds off while items keep coming, then the sender waits it out
    task automatic test_backpressure();
        hold_req = HOLD_LEN;
        @(negedge aclk);
        push_item(OP_MOVE, 32'd4, 1'b1, 16'd400);
        push_ticks(6);
        wait_drained();
    endtask

    function automatic logic [SPEED_W-1:0] pick_speed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return SPEED_W'($urandom_range(100, 1000));
        if (r < 70) return SPEED_W'($urandom_range(1001, 65535));
        if (r < 85) return SPEED_W'($urandom_range(0, 65535));
        return SPEED_W'($urandom_range(20, 99));
    endfunction

    // Random runs: mostly complete moves, some cut short, stops and noise
    task automatic test_random_runs();
        int kind;
        int n;
        int cnt;
        logic [SPEED_W-1:0] spd;
        int base;
        base = n_items;
        while (n_items - base < RAND_ITEMS) begin
            if ($urandom_range(0, 99) < 15) idle_on = !idle_on;
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                cnt = $urandom_range(1, 6);
                spd = pick_speed();
                push_item(OP_MOVE, COUNT_W'(cnt), 1'($urandom_range(0, 1)), spd);
                n = cnt * int'(ticks_per_step(spd));
                if (n > 40) n = 40;
                if ($urandom_range(0, 99) < 20) n = $urandom_range(0, n);
                else n += $urandom_range(0, 2);
                push_ticks(n);
            end else if (kind < 75) begin
                push_item(OP_MOVE, '0, 1'($urandom_range(0, 1)),
                          SPEED_W'($urandom_range(0, 65535)));
                push_ticks($urandom_range(0, 2));
            end else if (kind < 85) begin
                push_item(OP_MOVE, $urandom(), 1'($urandom_range(0, 1)),
                          SPEED_W'($urandom_range(0, 65535)));
                push_ticks($urandom_range(1, 5));
            end else begin
                repeat ($urandom_range(1, 6))
                    push_item(op_t'($urandom_range(0, 1)), $urandom(),
                              1'($urandom_range(0, 1)), SPEED_W'($urandom_range(0, 65535)));
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        s_valid      = 1'b0;
        s_op         = OP_TICK;
        s_step_count = '0;
        s_forward    = 1'b0;
        s_speed      = '0;
        aresetn      = 1'b0;
        errors       = 0;
        n_items      = 0;
        n_moves      = 0;
        n_steps      = 0;
        idle_cycles  = 0;
        hold_req     = 0;
        idle_on      = 1'b1;
        mot_phase    = '0;
        mot_coils    = '0;
        mot_left     = '0;
        mot_ivl      = MAX_INTERVAL;
        mot_cd       = '0;
        mot_dir      = 1'b0;
        mot_busy     = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_idle_ops();
        test_step_runs();
        test_replace_stop();
        test_slow_interval();
        test_backpressure();
        test_random_runs();

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Summary: %0d items, %0d moves, %0d steps made", n_items, n_moves, n_steps);
        $display("Covered idle ticks, replaced and stopped moves, slowest interval, long stalls");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/shsd_pkg.sv
sv/stepper_half_step_driver_top.sv
sim/tb_stepper_half_step_driver_top.sv
